@@ hdl/huffman_bit_decoder_macros.svh @@
// assertion macros shared by the checker
`ifndef HUFFMAN_BIT_DECODER_MACROS_SVH
`define HUFFMAN_BIT_DECODER_MACROS_SVH

// condition holds in the same cycle
`define HBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbd check failed");

// condition holds in the following cycle
`define HBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbd check failed");

`endif

@@ hdl/hbd_pkg.sv @@
// package: sizes, codes and types of the prefix-code decoder
package hbd_pkg;

    localparam int TABLE_DEPTH     = 128;
    localparam int LENGTH_LIMIT    = 16;
    localparam int SHORTEST_LENGTH = 1;

    localparam int LONGEST_LENGTH  = LENGTH_LIMIT - 1;
    localparam int ACC_W           = LENGTH_LIMIT - 1;
    localparam int LEN_W           = $clog2(LENGTH_LIMIT);
    localparam int IDX_W           = $clog2(TABLE_DEPTH);
    localparam int SCAN_W          = $clog2(TABLE_DEPTH + 1);
    localparam int SYM_W           = 8;
    localparam int EIU_W           = 8;
    localparam int FUNC_W          = 2;
    localparam int ENTRY_W         = SYM_W + LEN_W + ACC_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_BIT     = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] length;
        logic [ACC_W-1:0] pattern;
    } t_entry;

endpackage

@@ hdl/hbd_ram.sv @@
// generic single-port-write ram with registered read
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/huffman_bit_decoder.sv @@
// top level: table-driven prefix-code decoder
//
// Load, restart and unused commands leave busy low, as does a bit item taken
// while halted. Any other bit item raises busy while the code table memory
// is scanned in order, one entry read per cycle. With L = min(entries_in_use,
// 128) entries searched, busy stays high until an entry hits or all L entries
// miss. No entry is read when L is zero or when fewer bits than the shortest
// length are collected. The next item is taken once busy is low again. The
// result, if any, shows on o_symbol and o_status for the one cycle that
// o_strobe is high, which is the first cycle after busy falls; it must be
// taken then, there is no stall.
module huffman_bit_decoder
    import hbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [SYM_W-1:0]  i_entry_symbol,
    input  logic [LEN_W-1:0]  i_entry_length,
    input  logic [ACC_W-1:0]  i_entry_code,
    input  logic              i_code_bit,
    input  logic              i_cfg_we,
    input  logic [EIU_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [SYM_W-1:0]  o_symbol,
    output logic              o_status
);

    t_state             r_state, n_state;
    logic [SCAN_W-1:0]  r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_search, n_search;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_halted, n_halted;
    logic [EIU_W-1:0]   r_eiu;
    logic               r_strobe, n_strobe;
    logic [SYM_W-1:0]   r_symbol, n_symbol;
    logic               r_status, n_status;

    logic               accept;
    logic               bit_go;
    logic [SCAN_W-1:0]  limit;
    logic               rd_en;
    logic               hit;
    logic               scan_end;
    logic               ram_we;
    t_entry             wr_entry;
    t_entry             rd_entry;
    logic [ENTRY_W-1:0] rd_word;

    assign accept   = start && !busy;
    assign bit_go   = accept && (t_func'(i_func) == FUNC_BIT) && !r_halted;
    assign limit    = (32'(r_eiu) < TABLE_DEPTH) ? SCAN_W'(r_eiu) : SCAN_W'(TABLE_DEPTH);
    assign rd_en    = (r_state == ST_SCAN) && r_search && (r_idx < limit);
    assign rd_entry = t_entry'(rd_word);
    assign hit      = r_pend && (rd_entry.length == r_cnt) && (rd_entry.pattern == r_acc);
    assign scan_end = !r_pend && !rd_en;
    assign ram_we   = accept && (t_func'(i_func) == FUNC_LOAD);

    always_comb begin
        wr_entry.symbol  = i_entry_symbol;
        wr_entry.length  = i_entry_length;
        wr_entry.pattern = i_entry_code;
    end

    hbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_word)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (bit_go) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || scan_end) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_search = r_search;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_halted = r_halted;
        n_strobe = 1'b0;
        n_symbol = r_symbol;
        n_status = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority case (t_func'(i_func))
                        FUNC_BIT: begin
                            if (!r_halted) begin
                                n_acc = (r_acc << 1) | ACC_W'(i_code_bit);
                                if (32'(r_cnt) < LONGEST_LENGTH) begin
                                    n_cnt = r_cnt + LEN_W'(1);
                                end
                                n_search = 32'(n_cnt) >= SHORTEST_LENGTH;
                                n_idx    = '0;
                            end
                        end
                        FUNC_RESTART: begin
                            n_acc    = '0;
                            n_cnt    = '0;
                            n_halted = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                n_pend = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + SCAN_W'(1);
                end
                if (hit) begin
                    n_strobe = 1'b1;
                    n_symbol = rd_entry.symbol;
                    n_status = 1'b0;
                    n_acc    = '0;
                    n_cnt    = '0;
                end else if (scan_end && (32'(r_cnt) >= LONGEST_LENGTH)) begin
                    n_strobe = 1'b1;
                    n_symbol = '0;
                    n_status = 1'b1;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_halted = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_halted <= 1'b0;
            r_eiu    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_halted <= n_halted;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_eiu <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_search <= n_search;
        r_symbol <= n_symbol;
        r_status <= n_status;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_status = r_status;

endmodule

@@ hdl/hbd_checker.sv @@
// port-level checker for the prefix-code decoder, with its bind
`include "huffman_bit_decoder_macros.svh"

module hbd_checker
    import hbd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [FUNC_W-1:0] i_func,
    input logic              o_strobe,
    input logic [SYM_W-1:0]  o_symbol,
    input logic              o_status
);

    // an error result carries symbol zero
    `HBD_ASSERT_SAME(a_err_symbol, o_strobe && o_status, o_symbol == '0)

    // load, restart and unused commands finish at once
    `HBD_ASSERT_NEXT(a_quick_cmd, start && !busy && (i_func != FUNC_BIT), !busy && !o_strobe)

    // a result always follows a scan
    `HBD_ASSERT_SAME(a_strobe_after_scan, o_strobe, $past(busy) && !busy)

    // results never come in consecutive cycles
    `HBD_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe)

endmodule

bind huffman_bit_decoder hbd_checker u_hbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_func   (i_func),
    .o_strobe (o_strobe),
    .o_symbol (o_symbol),
    .o_status (o_status)
);
